### rtl/cht_pkg.sv
// Package for the two-way cuckoo hash table: sizes, payload and entry types,
// the controller state enum, the memory request struct and the hash helpers.
// No dependencies.
`default_nettype none

package cht_pkg;

  localparam int TABLE_BITS = 13;
  localparam int VALUE_BITS = 16;
  localparam int MAX_KICKS  = 32;

  localparam int KEY_W   = 64;
  localparam int IOVAL_W = 16;
  localparam int HASH2_LO = 16;
  localparam int KICK_W  = $clog2(MAX_KICKS + 1);

  typedef logic [TABLE_BITS-1:0] idx_t;
  typedef logic [KICK_W-1:0]     kick_t;

  typedef struct packed {
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [IOVAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [IOVAL_W-1:0] value_out;
    logic               insert_failed;
    logic [KEY_W-1:0]   dropped_key;
    logic [IOVAL_W-1:0] dropped_value;
  } out_t;

  typedef struct packed {
    logic                  used;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LK1,
    ST_LK2,
    ST_LK3,
    ST_INS_RD,
    ST_INS_WR,
    ST_PUSH
  } state_e;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  function automatic idx_t hash_one(input logic [KEY_W-1:0] k);
    return k[TABLE_BITS-1:0];
  endfunction

  function automatic idx_t hash_two(input logic [KEY_W-1:0] k);
    return k[HASH2_LO+TABLE_BITS-1:HASH2_LO];
  endfunction

  // Keep the low VALUE_BITS of an incoming value
  function automatic logic [VALUE_BITS-1:0] to_store(input logic [IOVAL_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[VALUE_BITS-1:0];
  endfunction

  // Report a stored value in the 16-bit result field
  function automatic logic [IOVAL_W-1:0] to_port(input logic [VALUE_BITS-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[IOVAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/cht_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Generic; no package dependency.
`default_nettype none

module cht_ram #(
  parameter int AW = 13,
  parameter int DW = 81
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/cht_ctrl.sv
// Controller of the cuckoo hash table: clearing pass, lookup probes and the
// insert/kick read-modify-write loop. Uses cht_pkg; drives the table RAM.
`default_nettype none

module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_t      in_data_i,
  output logic          in_ready_o,
  output ram_req_t      ram_req_o,
  input  wire entry_t   ram_rdata_i,
  output logic          res_valid_o,
  output out_t          res_o,
  input  wire logic     res_ready_i
);

  state_e state_q, state_d;
  idx_t   clr_q, clr_d;
  idx_t   idx_q, idx_d;
  kick_t  kicks_q, kicks_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  out_t   res_q, res_d;

  logic   accept;
  logic   fin;
  out_t   fin_res;
  logic   hit;
  logic   in_hand;
  idx_t   alt_idx;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign hit    = ram_rdata_i.used && (ram_rdata_i.key == key_q);
  assign in_hand = ram_rdata_i.used;
  assign alt_idx = (idx_q == hash_one(ram_rdata_i.key)) ? hash_two(ram_rdata_i.key)
                                                       : hash_one(ram_rdata_i.key);

  // Detect the last cycle of an item and form its result
  always_comb begin
    fin     = 1'b0;
    fin_res = '0;
    unique case (state_q)
      ST_LK2: begin
        if (hit) begin
          fin               = 1'b1;
          fin_res.found     = 1'b1;
          fin_res.value_out = to_port(ram_rdata_i.value);
        end
      end
      ST_LK3: begin
        fin = 1'b1;
        if (hit) begin
          fin_res.found     = 1'b1;
          fin_res.value_out = to_port(ram_rdata_i.value);
        end
      end
      ST_INS_WR: begin
        if (!in_hand) begin
          fin = 1'b1;
        end else if (kicks_q == KICK_W'(MAX_KICKS)) begin
          fin                   = 1'b1;
          fin_res.insert_failed = 1'b1;
          fin_res.dropped_key   = ram_rdata_i.key;
          fin_res.dropped_value = to_port(ram_rdata_i.value);
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.mode == MODE_LOOKUP) ? ST_LK1 : ST_INS_RD;
        end
      end
      ST_LK1:    state_d = ST_LK2;
      ST_LK2: begin
        if (!fin) state_d = ST_LK3;
        else state_d = res_ready_i ? ST_IDLE : ST_PUSH;
      end
      ST_LK3:    state_d = res_ready_i ? ST_IDLE : ST_PUSH;
      ST_INS_RD: state_d = ST_INS_WR;
      ST_INS_WR: begin
        if (!fin) state_d = ST_INS_RD;
        else state_d = res_ready_i ? ST_IDLE : ST_PUSH;
      end
      ST_PUSH: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Outputs: RAM request, result handoff, input ready
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ram_req_o       = '0;
    ram_req_o.raddr = idx_q;
    res_valid_o     = 1'b0;
    res_o           = fin_res;
    unique case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_q;
      end
      ST_LK1:    ram_req_o.raddr = hash_one(key_q);
      ST_LK2: begin
        ram_req_o.raddr = hash_two(key_q);
        res_valid_o     = fin;
      end
      ST_LK3:    res_valid_o = 1'b1;
      ST_INS_RD: ram_req_o.raddr = idx_q;
      ST_INS_WR: begin
        ram_req_o.we          = 1'b1;
        ram_req_o.waddr       = idx_q;
        ram_req_o.wdata.used  = 1'b1;
        ram_req_o.wdata.key   = key_q;
        ram_req_o.wdata.value = val_q;
        res_valid_o           = fin;
      end
      ST_PUSH: begin
        res_valid_o = 1'b1;
        res_o       = res_q;
      end
      default: begin
      end
    endcase
  end

  // Datapath registers: item in hand, slot index, kick count, pending result
  always_comb begin
    clr_d   = clr_q;
    idx_d   = idx_q;
    kicks_d = kicks_q;
    key_d   = key_q;
    val_d   = val_q;
    res_d   = res_q;
    if (state_q == ST_CLEAR) begin
      clr_d = clr_q + idx_t'(1);
    end
    if (accept) begin
      key_d   = in_data_i.key;
      val_d   = to_store(in_data_i.value);
      idx_d   = hash_one(in_data_i.key);
      kicks_d = '0;
    end
    // Take the evicted occupant in hand and move to its other slot
    if (state_q == ST_INS_WR && in_hand && !fin) begin
      key_d   = ram_rdata_i.key;
      val_d   = ram_rdata_i.value;
      idx_d   = alt_idx;
      kicks_d = kicks_q + kick_t'(1);
    end
    // Hold the result when the output stage is full
    if (fin && !res_ready_i) begin
      res_d = fin_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      kicks_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      kicks_q <= kicks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
    val_q <= val_d;
    res_q <= res_d;
  end

endmodule

`default_nettype wire

### rtl/cuckoo_hash_table.sv
// Top level of the two-way cuckoo hash table: table RAM, controller and the
// output register. Uses cht_pkg, cht_ram and cht_ctrl.
//
//   Port group                        Dir  Payload
//   in_valid_i / in_stall_o           in   in_data_i  (mode, key, value)
//   out_valid_o / out_stall_i         out  out_data_o (found, value_out,
//                                          insert_failed, dropped_key,
//                                          dropped_value)
//
// Lookup: probes the first slot, then the second on a miss, one RAM read
// per probe. Insert: each relocation is one read and one write of the
// single table RAM, at most MAX_KICKS relocations.
// After reset a clearing pass writes all 2**TABLE_BITS entries empty
// before the first item is taken.
// One item is in work at a time; a finished result waits in the output
// register so the next item can start while out_stall_i is high.
`default_nettype none

module cuckoo_hash_table
  import cht_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  ram_req_t ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic     in_ready;
  logic     res_valid;
  logic     res_ready;
  out_t     res;
  logic     out_valid_q;
  out_t     out_q;

  cht_ram #(
    .AW(TABLE_BITS),
    .DW(ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  cht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready),
    .ram_req_o   (ram_req),
    .ram_rdata_i (entry_t'(ram_rdata)),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign in_stall_o = !in_ready;
  assign res_ready  = !out_valid_q || !out_stall_i;

  // Output register: load a new result, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
